// File: rtl/core/crm_pkg.sv
// Package for the crossing range merger: sizes, payload types, command and status structs.
`default_nettype none
package crm_pkg;

  localparam int RangeDepth = 16;
  localparam int IdxW       = $clog2(RangeDepth);
  localparam int CntW       = $clog2(RangeDepth + 1);

  typedef struct packed {
    logic [31:0] src_line;
    logic [15:0] src_begin;
    logic [15:0] src_end;
    logic [15:0] src_words;
    logic [31:0] dst_line;
    logic [15:0] dst_begin;
    logic [15:0] dst_end;
    logic [15:0] dst_words;
    logic        end_of_stream;
  } in_t;

  typedef struct packed {
    logic [31:0] out_src_line;
    logic [15:0] out_src_begin;
    logic [15:0] out_src_end;
    logic [15:0] out_src_words;
    logic [31:0] out_dst_line;
    logic [15:0] out_dst_begin;
    logic [15:0] out_dst_end;
    logic [15:0] out_dst_words;
    logic        last_of_run;
    logic        overflow_seen;
  } out_t;

  // One stored range: positions {src_begin, src_end, dst_begin, dst_end}, sums {src, dst}.
  typedef struct packed {
    logic [63:0] pos;
    logic [31:0] sums;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic decide;
    logic promote;
    logic upd_cur;
    logic clear;
    logic old_clr;
    logic k_clr;
    logic k_inc;
    logic rd_en;
    logic rd_scan;
    logic push_in;
    logic push_merge;
    logic scan_inc;
    logic emit_old;
    logic emit_final;
  } cmd_t;

  typedef struct packed {
    logic grp_change;
    logic flush_cond;
    logic eos;
    logic k_done;
    logic scan_done;
    logic lt_end;
    logic gap;
    logic out_free;
    logic pend_valid;
  } status_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/crm_if.sv
// Stream interfaces for the input pairs and the emitted ranges.
`default_nettype none
interface crm_in_if;
  import crm_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface crm_out_if;
  import crm_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/crm_ctrl.sv
// Sequencer of the crossing range merger: steps one pair through decide, flush and scan.
`default_nettype none
module crm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire crm_pkg::status_t status_i,
  output crm_pkg::cmd_t         cmd_o
);
  import crm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_FL_CHK, S_FL_EM, S_SC_CHK, S_SC_CMP, S_EOS, S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   eos_mode_q, eos_mode_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    eos_mode_d = eos_mode_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        eos_mode_d   = 1'b0;
        if (status_i.grp_change) begin
          cmd_o.promote = 1'b1;
          cmd_o.k_clr   = 1'b1;
          if (status_i.flush_cond) begin
            state_d = S_FL_CHK;
          end else begin
            cmd_o.upd_cur = 1'b1;
            state_d       = S_SC_CHK;
          end
        end else begin
          state_d = S_SC_CHK;
        end
      end
      S_FL_CHK: begin
        if (status_i.k_done) begin
          cmd_o.old_clr = 1'b1;
          if (eos_mode_q) begin
            cmd_o.clear = 1'b1;
            state_d     = S_FINISH;
          end else begin
            cmd_o.upd_cur = 1'b1;
            state_d       = S_SC_CHK;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_FL_EM;
        end
      end
      S_FL_EM: begin
        if (status_i.out_free) begin
          cmd_o.emit_old = 1'b1;
          cmd_o.k_inc    = 1'b1;
          state_d        = S_FL_CHK;
        end
      end
      S_SC_CHK: begin
        if (status_i.scan_done) begin
          cmd_o.push_in = 1'b1;
          state_d       = S_EOS;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_scan = 1'b1;
          state_d       = S_SC_CMP;
        end
      end
      S_SC_CMP: begin
        priority if (status_i.lt_end) begin
          cmd_o.push_in = 1'b1;
          state_d       = S_EOS;
        end else if (status_i.gap) begin
          if (status_i.out_free) begin
            cmd_o.emit_old = 1'b1;
            cmd_o.scan_inc = 1'b1;
            state_d        = S_SC_CHK;
          end
        end else begin
          cmd_o.push_merge = 1'b1;
          cmd_o.scan_inc   = 1'b1;
          state_d          = S_EOS;
        end
      end
      S_EOS: begin
        if (status_i.eos) begin
          cmd_o.promote = 1'b1;
          cmd_o.k_clr   = 1'b1;
          eos_mode_d    = 1'b1;
          state_d       = S_FL_CHK;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.emit_final = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      eos_mode_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      eos_mode_q <= eos_mode_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/crm_datapath.sv
// Datapath of the crossing range merger: range memory, stream state and result registers.
`default_nettype none
module crm_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire crm_pkg::in_t     in_data_i,
  input  wire crm_pkg::cmd_t    cmd_i,
  output crm_pkg::status_t      status_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output crm_pkg::out_t         out_data_o
);
  import crm_pkg::*;

  // Two banks; bank_q selects the old list, the other bank holds the new list.
  entry_t mem_q [2][RangeDepth];
  entry_t rd_q;

  in_t            in_q;
  logic [31:0]    cur_sl_q, cur_dl_q;
  logic [15:0]    cur_se_q, grp_begin_q;
  logic           grp_active_q, bank_q, ovf_q, ovf_item_q;
  logic [CntW-1:0] old_cnt_q, new_cnt_q, scan_q, k_q;
  logic           out_valid_q, pend_valid_q;
  out_t           out_q, pend_q;

  entry_t push_entry;
  out_t   emit_rec;
  out_t   held_rec;
  logic   out_take;

  assign out_take = out_valid_q & out_ready_i;

  always_comb begin
    status_o.grp_change = !(grp_active_q && in_q.src_line == cur_sl_q &&
                            in_q.dst_line == cur_dl_q && in_q.src_begin == grp_begin_q);
    status_o.flush_cond = (in_q.src_line != cur_sl_q) || (in_q.dst_line != cur_dl_q) ||
                          (cur_se_q < in_q.src_begin);
    status_o.eos        = in_q.end_of_stream;
    status_o.k_done     = (k_q >= old_cnt_q);
    status_o.scan_done  = (scan_q >= old_cnt_q);
    status_o.lt_end     = (in_q.dst_end < rd_q.pos[15:0]);
    status_o.gap        = (rd_q.pos[15:0] < in_q.dst_begin);
    status_o.out_free   = !out_valid_q || out_ready_i;
    status_o.pend_valid = pend_valid_q;
  end

  always_comb begin
    if (cmd_i.push_merge) begin
      push_entry.pos  = {rd_q.pos[63:48], in_q.src_end, rd_q.pos[31:16], in_q.dst_end};
      push_entry.sums = {sat_add16(rd_q.sums[31:16], in_q.src_words),
                         sat_add16(rd_q.sums[15:0], in_q.dst_words)};
    end else begin
      push_entry.pos  = {in_q.src_begin, in_q.src_end, in_q.dst_begin, in_q.dst_end};
      push_entry.sums = {in_q.src_words, in_q.dst_words};
    end
  end

  always_comb begin
    emit_rec.out_src_line  = cur_sl_q;
    emit_rec.out_src_begin = rd_q.pos[63:48];
    emit_rec.out_src_end   = rd_q.pos[47:32];
    emit_rec.out_src_words = rd_q.sums[31:16];
    emit_rec.out_dst_line  = cur_dl_q;
    emit_rec.out_dst_begin = rd_q.pos[31:16];
    emit_rec.out_dst_end   = rd_q.pos[15:0];
    emit_rec.out_dst_words = rd_q.sums[15:0];
    emit_rec.last_of_run   = 1'b0;
    emit_rec.overflow_seen = ovf_item_q;
  end

  // The held-back result, marked as last when the pair's final emission releases it.
  always_comb begin
    held_rec             = pend_q;
    held_rec.last_of_run = cmd_i.emit_final;
  end

  // Range memory: one read, one write per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[bank_q][cmd_i.rd_scan ? scan_q[IdxW-1:0] : k_q[IdxW-1:0]];
    end
    if ((cmd_i.push_in || cmd_i.push_merge) && new_cnt_q < CntW'(RangeDepth)) begin
      mem_q[~bank_q][new_cnt_q[IdxW-1:0]] <= push_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_sl_q     <= '0;
      cur_dl_q     <= '1;
      cur_se_q     <= '0;
      grp_begin_q  <= '0;
      grp_active_q <= 1'b0;
      bank_q       <= 1'b0;
      ovf_q        <= 1'b0;
      ovf_item_q   <= 1'b0;
      old_cnt_q    <= '0;
      new_cnt_q    <= '0;
      scan_q       <= '0;
      k_q          <= '0;
    end else begin
      if (cmd_i.decide) begin
        ovf_item_q <= ovf_q | (!status_o.grp_change && new_cnt_q == CntW'(RangeDepth));
      end
      if (cmd_i.promote) begin
        bank_q    <= ~bank_q;
        old_cnt_q <= new_cnt_q;
        new_cnt_q <= '0;
        scan_q    <= '0;
      end
      if (cmd_i.push_in || cmd_i.push_merge) begin
        if (new_cnt_q < CntW'(RangeDepth)) begin
          new_cnt_q <= new_cnt_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.scan_inc) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.k_clr) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.old_clr) begin
        old_cnt_q <= '0;
      end
      if (cmd_i.upd_cur) begin
        cur_sl_q     <= in_q.src_line;
        cur_se_q     <= in_q.src_end;
        cur_dl_q     <= in_q.dst_line;
        grp_begin_q  <= in_q.src_begin;
        grp_active_q <= 1'b1;
      end
      if (cmd_i.clear) begin
        new_cnt_q    <= '0;
        scan_q       <= '0;
        cur_sl_q     <= '0;
        cur_se_q     <= '0;
        cur_dl_q     <= '1;
        grp_begin_q  <= '0;
        grp_active_q <= 1'b0;
      end
    end
  end

  // One result is held back so that the last one of a pair can be marked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if ((cmd_i.emit_old || cmd_i.emit_final) && pend_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.emit_old) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.emit_final) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.emit_old || cmd_i.emit_final) && pend_valid_q) begin
      out_q <= held_rec;
    end
    if (cmd_i.emit_old) begin
      pend_q <= emit_rec;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: rtl/core/crossing_range_merger.sv
// Top level of the crossing range merger: sequencer, datapath and checks.
`default_nettype none
// Channel  Direction  Handshake      Payload
// in_i     sink       valid/ready    one matched pair (crm_pkg::in_t)
// out_o    source     valid/ready    one emitted crossing range (crm_pkg::out_t)
//
// A pair is taken only when the sequencer is idle, and the next one only after decide, scan
// check, end of stream check and final emission. Every old range emitted by a flush or by
// the scan adds a read and an emit state, since the range memory has one read port with a
// registered read; every flush pass, the one at end of stream included, adds an end check,
// and a scan ending on a compare adds that compare. After reset all counts are zero and no
// clearing pass is needed. A stalled output holds the sequencer at its next emission; the
// final result of a pair leaves the output register while the next pair is being taken.
module crossing_range_merger (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  crm_in_if.sink     in_i,
  crm_out_if.source  out_o
);
  import crm_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // The sequencer decides what happens in each cycle; the datapath only obeys commands.
  crm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the old and new range lists in two banks of one memory, so that
  // promoting the new list to the old one is a bank swap rather than a copy.
  crm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

  assign in_i.ready = in_ready;

`ifndef SYNTH
  // A new pair is never taken while a result of the previous one is still held back.
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !status.pend_valid)
    else $error("pair taken with a held-back result");

  // After a transfer on the input the sequencer is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> !in_ready)
    else $error("input ready directly after a transfer");

  // Emissions are only issued when the output register can take them.
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_old || cmd.emit_final) |-> status.out_free)
    else $error("emission into a full output register");
`endif

endmodule
`default_nettype wire

// File: dv/crossing_range_merger_tb.sv
// Self-checking testbench for the crossing range merger: directed table, random chains, predictor.
`timescale 1ns / 100ps
module crossing_range_merger_tb;
  import crm_pkg::*;

  // The predictor below keeps its own copy of the range lists, so everything that
  // is compared at the output comes from this file alone.

  logic clk;
  logic rst_n;

  crm_in_if  pair_bus ();
  crm_out_if range_bus ();

  crossing_range_merger i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (pair_bus),
    .out_o  (range_bus)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // One row of the directed table. Where the expected range can be read straight off
  // the pair, it is typed in and replaces the predicted one.
  typedef struct {
    in_t  pair;
    bit   typed;
    out_t range;
  } dir_row_t;

  // Predictor state: the old list being scanned and the new list being built.
  entry_t      old_ranges [RangeDepth];
  entry_t      new_ranges [RangeDepth];
  int unsigned old_cnt, new_cnt, scan_idx;
  logic [31:0] cur_src_line, cur_dst_line;
  logic [15:0] cur_src_end, grp_begin;
  bit          grp_open, lost_range;

  out_t        expected_ranges [$];
  int          n_pairs, n_ranges, n_errors;
  bit          idling_on;

  function automatic void append_range(ref out_t q[$], input out_t r);
    q.insert(q.size(), r);
  endfunction

  function automatic void append_row(ref dir_row_t q[$], input dir_row_t r);
    q.insert(q.size(), r);
  endfunction

  function automatic logic [15:0] words_sum(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[16]) return 16'hFFFF;
    return s[15:0];
  endfunction

  function automatic out_t range_of(entry_t e);
    out_t r;
    r.out_src_line  = cur_src_line;
    r.out_src_begin = e.pos[63:48];
    r.out_src_end   = e.pos[47:32];
    r.out_src_words = e.sums[31:16];
    r.out_dst_line  = cur_dst_line;
    r.out_dst_begin = e.pos[31:16];
    r.out_dst_end   = e.pos[15:0];
    r.out_dst_words = e.sums[15:0];
    r.last_of_run   = 1'b0;
    r.overflow_seen = 1'b0;
    return r;
  endfunction

  function automatic void store_new(entry_t e);
    if (new_cnt < RangeDepth) begin
      new_ranges[new_cnt] = e;
      new_cnt++;
    end else begin
      lost_range = 1'b1;
    end
  endfunction

  function automatic void promote_new();
    old_ranges = new_ranges;
    old_cnt    = new_cnt;
    new_cnt    = 0;
    scan_idx   = 0;
  endfunction

  function automatic void flush_old(ref out_t batch[$]);
    for (int k = 0; k < old_cnt; k++) append_range(batch, range_of(old_ranges[k]));
    old_cnt = 0;
  endfunction

  function automatic void restart_stream();
    old_cnt      = 0;
    new_cnt      = 0;
    scan_idx     = 0;
    cur_src_line = '0;
    cur_src_end  = '0;
    cur_dst_line = '1;
    grp_begin    = '0;
    grp_open     = 1'b0;
  endfunction

  // Works out every range that one accepted pair releases, in order.
  function automatic void chain_pair(in_t p, ref out_t batch[$]);
    entry_t e, own;
    bit     done;
    own.pos  = {p.src_begin, p.src_end, p.dst_begin, p.dst_end};
    own.sums = {p.src_words, p.dst_words};
    if (!(grp_open && p.src_line == cur_src_line && p.dst_line == cur_dst_line &&
          p.src_begin == grp_begin)) begin
      promote_new();
      // A new line on either side, or a source gap, ends every open range.
      if (p.src_line != cur_src_line || p.dst_line != cur_dst_line ||
          cur_src_end < p.src_begin) flush_old(batch);
      cur_src_line = p.src_line;
      cur_src_end  = p.src_end;
      cur_dst_line = p.dst_line;
      grp_begin    = p.src_begin;
      grp_open     = 1'b1;
    end
    done = 1'b0;
    while (!done) begin
      if (scan_idx >= old_cnt) begin
        store_new(own);
        done = 1'b1;
      end else begin
        e = old_ranges[scan_idx];
        if (p.dst_end < e.pos[15:0]) begin
          store_new(own);
          done = 1'b1;
        end else if (e.pos[15:0] < p.dst_begin) begin
          // Old range ends before this pair in the destination: it is complete.
          append_range(batch, range_of(e));
          scan_idx++;
        end else begin
          e.pos  = {e.pos[63:48], p.src_end, e.pos[31:16], p.dst_end};
          e.sums = {words_sum(e.sums[31:16], p.src_words),
                    words_sum(e.sums[15:0], p.dst_words)};
          store_new(e);
          scan_idx++;
          done = 1'b1;
        end
      end
    end
    if (p.end_of_stream) begin
      promote_new();
      flush_old(batch);
      restart_stream();
    end
    foreach (batch[k]) begin
      batch[k].last_of_run   = (k == batch.size() - 1);
      batch[k].overflow_seen = lost_range;
    end
  endfunction

  function automatic in_t mk_pair(logic [31:0] sl, logic [15:0] sb, logic [15:0] se,
                                  logic [15:0] sw, logic [31:0] dl, logic [15:0] db,
                                  logic [15:0] de, logic [15:0] dw, logic eos);
    in_t p;
    p = '{sl, sb, se, sw, dl, db, de, dw, eos};
    return p;
  endfunction

  // The range that a lone pair closed by end of stream comes out as.
  function automatic out_t lone_range(in_t p);
    out_t r;
    r = '{p.src_line, p.src_begin, p.src_end, p.src_words, p.dst_line,
          p.dst_begin, p.dst_end, p.dst_words, 1'b1, 1'b0};
    return r;
  endfunction

  // Offers one pair, waits for its transfer and records what it should release.
  task automatic send_pair(in_t p, bit typed = 1'b0, out_t typed_range = '0);
    out_t batch[$];
    if (idling_on && $urandom_range(0, 99) < 15) begin
      pair_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pair_bus.valid <= 1'b1;
    pair_bus.data  <= p;
    do @(posedge clk); while (!pair_bus.ready);
    chain_pair(p, batch);
    n_pairs++;
    if (typed) begin
      if (batch.size() != 1) begin
        $error("typed row: predictor gives %0d ranges, table gives 1", batch.size());
        n_errors++;
      end
      append_range(expected_ranges, typed_range);
    end else begin
      foreach (batch[k]) append_range(expected_ranges, batch[k]);
    end
  endtask

  // Receiver side: stalls at random, except during the quiet stretch.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      range_bus.ready <= 1'b0;
    end else begin
      range_bus.ready <= !idling_on || ($urandom_range(0, 99) >= 15);
    end
  end

  // Compares every transferred range with the oldest expectation, field by field.
  always @(posedge clk) begin
    out_t want, got;
    if (rst_n && range_bus.valid && range_bus.ready) begin
      got = range_bus.data;
      n_ranges++;
      if (expected_ranges.size() == 0) begin
        $error("range transferred with nothing expected: %h", got);
        n_errors++;
      end else begin
        want = expected_ranges.pop_front();
        if (got.out_src_line !== want.out_src_line) begin
          $error("out_src_line: expected %h, got %h", want.out_src_line, got.out_src_line);
          n_errors++;
        end
        if (got.out_src_begin !== want.out_src_begin) begin
          $error("out_src_begin: expected %h, got %h", want.out_src_begin, got.out_src_begin);
          n_errors++;
        end
        if (got.out_src_end !== want.out_src_end) begin
          $error("out_src_end: expected %h, got %h", want.out_src_end, got.out_src_end);
          n_errors++;
        end
        if (got.out_src_words !== want.out_src_words) begin
          $error("out_src_words: expected %h, got %h", want.out_src_words, got.out_src_words);
          n_errors++;
        end
        if (got.out_dst_line !== want.out_dst_line) begin
          $error("out_dst_line: expected %h, got %h", want.out_dst_line, got.out_dst_line);
          n_errors++;
        end
        if (got.out_dst_begin !== want.out_dst_begin) begin
          $error("out_dst_begin: expected %h, got %h", want.out_dst_begin, got.out_dst_begin);
          n_errors++;
        end
        if (got.out_dst_end !== want.out_dst_end) begin
          $error("out_dst_end: expected %h, got %h", want.out_dst_end, got.out_dst_end);
          n_errors++;
        end
        if (got.out_dst_words !== want.out_dst_words) begin
          $error("out_dst_words: expected %h, got %h", want.out_dst_words, got.out_dst_words);
          n_errors++;
        end
        if (got.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
          n_errors++;
        end
        if (got.overflow_seen !== want.overflow_seen) begin
          $error("overflow_seen: expected %b, got %b", want.overflow_seen, got.overflow_seen);
          n_errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t    rows [$];
    in_t         p;
    logic [31:0] sl, dl;
    logic [15:0] sb, db;
    int          roll;

    rst_n          = 1'b0;
    pair_bus.valid = 1'b0;
    pair_bus.data  = '0;
    idling_on      = 1'b1;
    n_pairs        = 0;
    n_ranges       = 0;
    n_errors       = 0;
    lost_range     = 1'b0;
    restart_stream();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Lone pairs closed by end of stream are typed in; the chains
    // that follow are left to the predictor.
    p = mk_pair(32'd1, 16'd3, 16'd4, 16'd2, 32'd7, 16'd9, 16'd10, 16'd1, 1'b1);
    append_row(rows, '{p, 1'b1, lone_range(p)});
    p = mk_pair('1, '1, '1, '1, '1, '1, '1, '1, 1'b1);
    append_row(rows, '{p, 1'b1, lone_range(p)});
    p = mk_pair('0, '0, '0, '0, '0, '0, '0, '0, 1'b1);
    append_row(rows, '{p, 1'b1, lone_range(p)});
    // First group on line 5: three ranges side by side in the destination.
    append_row(rows, '{mk_pair(5, 0, 2, 60000, 9, 0, 1, 60000, 0), 1'b0, '0});
    append_row(rows, '{mk_pair(5, 0, 2, 1, 9, 4, 5, 1, 0), 1'b0, '0});
    append_row(rows, '{mk_pair(5, 0, 2, 1, 9, 8, 9, 1, 0), 1'b0, '0});
    // Next group extends the first range (words saturate), skips the second and
    // adds a pair of its own before the third.
    append_row(rows, '{mk_pair(5, 2, 3, 60000, 9, 1, 2, 60000, 0), 1'b0, '0});
    append_row(rows, '{mk_pair(5, 2, 3, 3, 9, 7, 7, 3, 0), 1'b0, '0});
    // Same source line, begin past the group's end: a gap flushes everything.
    append_row(rows, '{mk_pair(5, 9, 10, 2, 9, 3, 4, 2, 0), 1'b0, '0});
    append_row(rows, '{mk_pair(5, 10, 11, 2, 9, 4, 6, 2, 0), 1'b0, '0});
    // Destination line change flushes, then the source line changes too.
    append_row(rows, '{mk_pair(5, 11, 12, 4, 10, 0, 2, 4, 0), 1'b0, '0});
    append_row(rows, '{mk_pair(6, 0, 1, 4, 10, 3, 5, 4, 0), 1'b0, '0});
    append_row(rows, '{mk_pair(6, 1, 2, 5, 10, 5, 6, 5, 0), 1'b0, '0});
    append_row(rows, '{mk_pair(6, 1, 2, 5, 10, 20, 21, 5, 1), 1'b0, '0});
    foreach (rows[i]) send_pair(rows[i].pair, rows[i].typed, rows[i].range);

    // Random part: mostly sorted chains with random content, some noise and
    // early ends of stream. A quiet stretch in the middle has no idling at all.
    sl = 32'd100;
    dl = 32'd200;
    sb = 16'd0;
    db = 16'd0;
    for (int i = 0; i < 120; i++) begin
      idling_on = !(i >= 50 && i < 90);
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        p = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      end else begin
        if ($urandom_range(0, 99) < 25) begin
          sb = 16'(sb + $urandom_range(0, 2));
          db = 16'($urandom_range(0, 4));
          if ($urandom_range(0, 99) < 10) sl = sl + 1;
          if ($urandom_range(0, 99) < 8)  dl = dl + 1;
        end
        db = 16'(db + $urandom_range(0, 3));
        p = mk_pair(sl, sb, 16'(sb + $urandom_range(1, 3)),
                    ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9)),
                    dl, db, 16'(db + $urandom_range(0, 3)),
                    ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9)),
                    roll >= 94);
      end
      send_pair(p);
    end

    // Closing sequence: one group too wide for the list, so the sticky overflow
    // flag rises and stays up for the rest of the run.
    for (int i = 0; i < RangeDepth + 2; i++)
      send_pair(mk_pair(32'd3, 16'd1, 16'd2, 16'd1, 32'd4, 16'(2 * i), 16'(2 * i), 16'd1,
                        i == RangeDepth + 1));
    pair_bus.valid <= 1'b0;

    while (expected_ranges.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Run covered %0d pairs and %0d checked ranges, with chains, gaps,",
             n_pairs, n_ranges);
    $display("line changes, saturating word sums and list overflow.");
    if (n_errors == 0 && expected_ranges.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Far beyond the slowest legal run, including every receiver stall.
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: crossing_range_merger.f
rtl/core/crm_pkg.sv
rtl/core/crm_if.sv
rtl/core/crm_ctrl.sv
rtl/core/crm_datapath.sv
rtl/core/crossing_range_merger.sv
dv/crossing_range_merger_tb.sv
